// ===== rtl/aging_priority_queue_core_macros.svh =====
// Assertion macros for the aging priority queue.
`ifndef AGING_PRIORITY_QUEUE_CORE_MACROS_SVH
`define AGING_PRIORITY_QUEUE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Property checked every clock edge outside reset.
`define APQ_ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("apq assertion failed");

// Condition that must never hold outside reset.
`define APQ_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("apq forbidden condition");

`else

`define APQ_ASSERT_PROP(lbl, clk, rst_n, prop)
`define APQ_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== rtl/apq_pkg.sv =====
package apq_pkg;

    localparam int PRIO_W = 8;
    localparam int TAG_W  = 8;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2,
        OP_NOP  = 2'd3
    } op_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [PRIO_W-1:0] PRIO_MAX = '1;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH_WALK,
        S_PUSH_LAST,
        S_POP_HEAD,
        S_POP_WALK,
        S_RESP
    } state_t;

    typedef struct packed {
        logic accept;
        logic push_step;
        logic push_last;
        logic pop_head;
        logic pop_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic push_go;
        logic idx_zero;
        logic pop_more;
        logic pop_last;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/apq_ctrl.sv =====
`include "aging_priority_queue_core_macros.svh"

module apq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  apq_pkg::op_t  op_in,
    input  apq_pkg::sts_t sts,
    output apq_pkg::cmd_t cmd
);
    import apq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (op_in)
                        OP_PUSH:
                        begin
                            if (sts.full || sts.empty)
                                state_next = S_RESP;
                            else
                                state_next = S_PUSH_WALK;
                        end
                        OP_POP, OP_PEEK:
                        begin
                            if (sts.empty)
                                state_next = S_RESP;
                            else
                                state_next = S_POP_HEAD;
                        end
                        default: state_next = S_RESP;
                    endcase
                end
            end
            S_PUSH_WALK:
            begin
                if (!sts.push_go)
                    state_next = S_RESP;
                else if (sts.idx_zero)
                    state_next = S_PUSH_LAST;
            end
            S_PUSH_LAST: state_next = S_RESP;
            S_POP_HEAD:
            begin
                if (sts.pop_more)
                    state_next = S_POP_WALK;
                else
                    state_next = S_RESP;
            end
            S_POP_WALK:
            begin
                if (sts.pop_last)
                    state_next = S_RESP;
            end
            S_RESP:
            begin
                if (sts.out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        in_ready      = (state_reg == S_IDLE);
        cmd.accept    = (state_reg == S_IDLE) && in_valid;
        cmd.push_step = (state_reg == S_PUSH_WALK);
        cmd.push_last = (state_reg == S_PUSH_LAST);
        cmd.pop_head  = (state_reg == S_POP_HEAD);
        cmd.pop_step  = (state_reg == S_POP_WALK);
        cmd.out_load  = (state_reg == S_RESP) && sts.out_free;
    end

    // one job in flight at a time
    `APQ_ASSERT_PROP(a_one_job, clk, rst_n, cmd.accept |=> !in_ready)

endmodule

// ===== rtl/apq_datapath.sv =====
`include "aging_priority_queue_core_macros.svh"

module apq_datapath #(
    parameter int CAPACITY = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  apq_pkg::op_t                op_in,
    input  logic [apq_pkg::PRIO_W-1:0]  prio_in,
    input  logic [apq_pkg::TAG_W-1:0]   tag_in,
    input  apq_pkg::cmd_t               cmd,
    output apq_pkg::sts_t               sts,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  status,
    output logic [apq_pkg::PRIO_W-1:0]  out_priority,
    output logic [apq_pkg::TAG_W-1:0]   out_tag
);
    import apq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    entry_t mem [CAPACITY];
    entry_t rd_data_reg;

    logic [CW-1:0] occ_reg;
    logic [CW-1:0] occ_next;
    logic [AW-1:0] idx_reg;
    logic [AW-1:0] idx_next;
    logic          out_valid_reg;
    logic          out_valid_next;

    op_t               op_reg;
    logic [PRIO_W-1:0] pr_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [1:0]        res_status_reg;
    logic [1:0]        res_status_next;
    entry_t            res_entry_reg;
    entry_t            res_entry_next;
    logic [1:0]        out_status_reg;
    entry_t            out_entry_reg;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    entry_t        aged;

    always_comb
    begin
        aged.tag  = rd_data_reg.tag;
        aged.prio = (rd_data_reg.prio == PRIO_MAX) ? PRIO_MAX
                                                   : rd_data_reg.prio + PRIO_W'(1);
    end

    always_comb
    begin
        sts.full     = (occ_reg == CW'(CAPACITY));
        sts.empty    = (occ_reg == '0);
        sts.push_go  = (rd_data_reg.prio >= pr_reg);
        sts.idx_zero = (idx_reg == '0);
        sts.pop_more = (op_reg == OP_POP) && (occ_reg != '0);
        sts.pop_last = (CW'(idx_reg) == occ_reg);
        sts.out_free = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        occ_next        = occ_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_entry_next  = res_entry_reg;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;
        rd_en           = 1'b0;
        rd_addr         = '0;
        out_valid_next  = out_valid_reg && !out_ready;

        if (cmd.accept)
        begin
            res_status_next = ST_OK;
            res_entry_next  = '0;
            case (op_in)
                OP_PUSH:
                begin
                    if (sts.full)
                    begin
                        res_status_next = ST_FULL;
                    end
                    else
                    begin
                        occ_next = occ_reg + CW'(1);
                        if (sts.empty)
                        begin
                            wr_en        = 1'b1;
                            wr_data.prio = prio_in;
                            wr_data.tag  = tag_in;
                        end
                        else
                        begin
                            idx_next = AW'(occ_reg - CW'(1));
                            rd_en    = 1'b1;
                            rd_addr  = AW'(occ_reg - CW'(1));
                        end
                    end
                end
                OP_POP, OP_PEEK:
                begin
                    if (sts.empty)
                    begin
                        res_status_next = ST_EMPTY;
                    end
                    else
                    begin
                        rd_en = 1'b1;
                        if (op_in == OP_POP)
                            occ_next = occ_reg - CW'(1);
                    end
                end
                default: ;
            endcase
        end

        if (cmd.push_step)
        begin
            wr_en   = 1'b1;
            wr_addr = idx_reg + AW'(1);
            if (sts.push_go)
            begin
                wr_data = aged;
                if (!sts.idx_zero)
                begin
                    idx_next = idx_reg - AW'(1);
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg - AW'(1);
                end
            end
            else
            begin
                wr_data.prio = pr_reg;
                wr_data.tag  = tag_reg;
            end
        end

        if (cmd.push_last)
        begin
            wr_en        = 1'b1;
            wr_data.prio = pr_reg;
            wr_data.tag  = tag_reg;
        end

        if (cmd.pop_head)
        begin
            res_entry_next = rd_data_reg;
            if (sts.pop_more)
            begin
                idx_next = AW'(1);
                rd_en    = 1'b1;
                rd_addr  = AW'(1);
            end
        end

        if (cmd.pop_step)
        begin
            wr_en   = 1'b1;
            wr_addr = idx_reg - AW'(1);
            wr_data = rd_data_reg;
            if (!sts.pop_last)
            begin
                idx_next = idx_reg + AW'(1);
                rd_en    = 1'b1;
                rd_addr  = idx_reg + AW'(1);
            end
        end

        if (cmd.out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= op_in;
            pr_reg  <= prio_in;
            tag_reg <= tag_in;
        end
        res_status_reg <= res_status_next;
        res_entry_reg  <= res_entry_next;
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_entry_reg  <= res_entry_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg       <= occ_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign out_priority = out_entry_reg.prio;
    assign out_tag      = out_entry_reg.tag;

    `APQ_ASSERT_NEVER(a_occ_bound, clk, rst_n, occ_reg > CW'(CAPACITY))
    `APQ_ASSERT_PROP(a_push_idx, clk, rst_n, cmd.push_step |-> (CW'(idx_reg) + CW'(1) < occ_reg))
    `APQ_ASSERT_PROP(a_pop_idx, clk, rst_n, cmd.pop_step |-> (idx_reg != '0 && CW'(idx_reg) <= occ_reg))

endmodule

// ===== rtl/aging_priority_queue_core.sv =====
// Sorted job queue with aging, CAPACITY entries in a single-port-write,
// single-port-read memory (slot 0 is the front, lowest priority first). A push
// inserts ahead of the first job of equal or higher priority value and adds one
// (saturating at 255) to every job behind it; pop and peek return the front job.
// Each operation is one input beat and one result beat. A push into a non-empty
// queue and a pop from more than one job walk over the memory, one slot per
// cycle; a peek, a push into an empty queue and an error do not walk. The next
// beat is accepted once the result has moved into the output register; a result
// that finds that register still occupied holds the input off until it is taken.
module aging_priority_queue_core #(
    parameter int CAPACITY = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  opcode,
    input  logic [apq_pkg::PRIO_W-1:0]  job_priority,
    input  logic [apq_pkg::TAG_W-1:0]   job_tag,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  status,
    output logic [apq_pkg::PRIO_W-1:0]  out_priority,
    output logic [apq_pkg::TAG_W-1:0]   out_tag
);
    import apq_pkg::*;

    op_t  op_in;
    cmd_t cmd;
    sts_t sts;

    assign op_in = op_t'(opcode);

    apq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .op_in    (op_in),
        .sts      (sts),
        .cmd      (cmd)
    );

    apq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .op_in        (op_in),
        .prio_in      (job_priority),
        .tag_in       (job_tag),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .out_priority (out_priority),
        .out_tag      (out_tag)
    );

endmodule
